FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define AST_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fpjs_pkg.sv
package fpjs_pkg;

  localparam int PRIORITY_BITS = 8;
  localparam int TICK_BITS     = 32;
  localparam int TASK_BITS     = 8;
  localparam int JOB_BITS      = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef struct packed {
    logic                     has_job;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [TICK_BITS-1:0]     rel_tick;
    logic [TASK_BITS-1:0]     task_id;
    logic [JOB_BITS-1:0]      job_id;
    logic                     is_ready;
    logic                     last;
  } job_beat_t;

  typedef struct packed {
    logic [TASK_BITS-1:0] sel_task_id;
    logic [JOB_BITS-1:0]  sel_job_id;
    status_t              status;
  } sel_beat_t;

endpackage

FILE: sv/fpjs_in_stage.sv
// Input register: holds one job beat until the select stage takes it.
module fpjs_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_stall,
  input  fpjs_pkg::job_beat_t job,
  input  logic                out_free,
  output logic                s1_valid,
  output fpjs_pkg::job_beat_t s1,
  output logic                s1_adv
);
  import fpjs_pkg::*;

  // A last beat needs room in the result register; others always move.
  assign s1_adv    = s1_valid && (!s1.last || out_free);
  assign job_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!job_stall) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!job_stall && job_valid) begin
      s1 <= job;
    end
  end

endmodule

FILE: sv/fpjs_best.sv
// Running best job and the result for the list closed by the current beat.
module fpjs_best (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_adv,
  input  fpjs_pkg::job_beat_t s1,
  output fpjs_pkg::sel_beat_t res
);
  import fpjs_pkg::*;

  logic [PRIORITY_BITS-1:0] best_priority;
  logic [TICK_BITS-1:0]     best_release;
  logic [TASK_BITS-1:0]     best_task;
  logic [JOB_BITS-1:0]      best_job;
  logic                     have_best;
  logic                     saw_not_ready;

  logic precedes;
  logic upd;
  logic nr_next;
  logic hb_next;

  // Lexicographic key: priority, release, task, job; ties keep the held job.
  always_comb begin
    if (s1.priority_req != best_priority) begin
      precedes = s1.priority_req < best_priority;
    end else if (s1.rel_tick != best_release) begin
      precedes = s1.rel_tick < best_release;
    end else if (s1.task_id != best_task) begin
      precedes = s1.task_id < best_task;
    end else begin
      precedes = s1.job_id < best_job;
    end
  end

  assign upd     = s1.has_job && s1.is_ready && (!have_best || precedes);
  assign nr_next = saw_not_ready || (s1.has_job && !s1.is_ready);
  assign hb_next = have_best || upd;

  always_comb begin
    if (nr_next) begin
      res = '{sel_task_id: '0, sel_job_id: '0, status: ST_NOT_READY};
    end else if (!hb_next) begin
      res = '{sel_task_id: '0, sel_job_id: '0, status: ST_EMPTY};
    end else if (upd) begin
      res = '{sel_task_id: s1.task_id, sel_job_id: s1.job_id, status: ST_OK};
    end else begin
      res = '{sel_task_id: best_task, sel_job_id: best_job, status: ST_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best     <= 1'b0;
      saw_not_ready <= 1'b0;
    end else if (s1_adv) begin
      have_best     <= hb_next && !s1.last;
      saw_not_ready <= nr_next && !s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && upd) begin
      best_priority <= s1.priority_req;
      best_release  <= s1.rel_tick;
      best_task     <= s1.task_id;
      best_job      <= s1.job_id;
    end
  end

endmodule

FILE: sv/fpjs_out_stage.sv
// Result register toward the receiver.
module fpjs_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fpjs_pkg::sel_beat_t res,
  output logic                sel_valid,
  input  logic                sel_stall,
  output fpjs_pkg::sel_beat_t sel,
  output logic                out_free
);
  import fpjs_pkg::*;

  assign out_free = !sel_valid || !sel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (out_free) begin
      sel_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sel <= res;
    end
  end

endmodule

FILE: sv/fixed_priority_job_select_core.sv
// Fixed-priority job selection over a streamed ready list.
// Job channel (job_valid/job_stall/job): one beat per list entry; the beat
// with last set closes the list. An empty list is a single last beat with
// has_job clear. Non-ready jobs are skipped but flag the list.
// Select channel (sel_valid/sel_stall/sel): one beat per closed list with the
// winning task and job id and a status (ok, non-ready seen, empty list); ids
// are zero unless status is ok.
// Ordering: smaller priority, then earlier release, then smaller task id,
// then smaller job id; an equal key never displaces the held job.
// Throughput: one job beat per cycle, set by the single compare-and-update
// of the running best; a last beat waits while the result register is busy.
// Result path: a last beat is taken into the input register, then loaded
// into the result register once that register is free.
// Reset: synchronous; drops any held beat, the result and the running best.
// Receiver stall: the result register holds; further non-last beats keep
// streaming, and a last beat waits in the input register, raising job_stall,
// until the result register frees.
module fixed_priority_job_select_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_stall,
  input  fpjs_pkg::job_beat_t job,
  output logic                sel_valid,
  input  logic                sel_stall,
  output fpjs_pkg::sel_beat_t sel
);
  import fpjs_pkg::*;

  `include "assert_macros.svh"

  logic      s1_valid;
  job_beat_t s1;
  logic      s1_adv;
  logic      out_free;
  sel_beat_t res;

  // Stage 1: input register.
  fpjs_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .out_free  (out_free),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_adv    (s1_adv)
  );

  // Compare against the running best; builds the result for a last beat.
  fpjs_best u_best (
    .clk    (clk),
    .rst    (rst),
    .s1_adv (s1_adv),
    .s1     (s1),
    .res    (res)
  );

  // Stage 2: result register.
  fpjs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && s1.last),
    .res       (res),
    .sel_valid (sel_valid),
    .sel_stall (sel_stall),
    .sel       (sel),
    .out_free  (out_free)
  );

  // Back pressure only comes from a held beat.
  `AST_CLK(a_stall_needs_beat, job_stall |-> s1_valid, "stall with empty input register")

  // A moving last beat always lands in the result register.
  `AST_CLK(a_last_lands, (s1_adv && s1.last) |=> sel_valid, "closed list lost")

  // Non-ok results carry zero ids.
  `AST_CLK(a_zero_ids,
           (sel_valid && sel.status != ST_OK) |->
           (sel.sel_task_id == '0 && sel.sel_job_id == '0),
           "non-ok result with nonzero ids")

  // Reset empties the result register.
  `AST_ALL(a_reset_clears, $past(rst) |-> !sel_valid, "result valid after reset")

endmodule

FILE: test/testbench.sv
// Fixed-priority job select: streams ready lists through the core and checks
// every selection beat against a predictor of the running best job.
module testbench;
  import fpjs_pkg::*;

  // Far above the slowest legal run. That run is about 700 job beats with
  // the longest sender gaps, each list closing into a long receiver stall.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_JOBS = 650;
  localparam int DRAIN_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      job_valid = 1'b0;
  logic      job_stall;
  job_beat_t job       = '0;
  logic      sel_valid;
  logic      sel_stall = 1'b0;
  sel_beat_t sel;

  fixed_priority_job_select_core DUT (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .sel_valid (sel_valid),
    .sel_stall (sel_stall),
    .sel       (sel)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: the running best job of the open list
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [PRIORITY_BITS-1:0] pri;
    logic [TICK_BITS-1:0]     rel;
    logic [TASK_BITS-1:0]     tsk;
    logic [JOB_BITS-1:0]      jid;
    logic                     held;           // a ready job is held
    logic                     saw_not_ready;  // list is tainted
  } running_best_t;

  running_best_t running_best = '0;
  sel_beat_t     expected_sels[$];   // selections still owed by the core
  sel_beat_t     want_sel;
  int            fail_count = 0;
  int            cycle_count = 0;

  // Folds one job beat into the running best. A beat with last set closes
  // the list and queues the selection that the core owes for it.
  function automatic void track_job(job_beat_t b);
    sel_beat_t r;
    if (b.has_job) begin
      if (!b.is_ready) begin
        // skipped for the compare, but the list result is forced non-ok
        running_best.saw_not_ready = 1'b1;
      end else if (!running_best.held ||
                   {b.priority_req, b.rel_tick, b.task_id, b.job_id} <
                   {running_best.pri, running_best.rel, running_best.tsk,
                    running_best.jid}) begin
        // the key compare is strict, so an equal key keeps the first job
        running_best.pri  = b.priority_req;
        running_best.rel  = b.rel_tick;
        running_best.tsk  = b.task_id;
        running_best.jid  = b.job_id;
        running_best.held = 1'b1;
      end
    end
    if (b.last) begin
      r = '0;
      if (running_best.saw_not_ready) begin
        r.status = ST_NOT_READY;      // ids stay zero
      end else if (!running_best.held) begin
        r.status = ST_EMPTY;          // ids stay zero
      end else begin
        r.sel_task_id = running_best.tsk;
        r.sel_job_id  = running_best.jid;
        r.status      = ST_OK;
      end
      expected_sels.push_back(r);
      running_best = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Job channel driver: bursts of back-to-back beats, random gaps between
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_beat(input job_beat_t b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // about a quarter of the bursts follow the previous one with no gap
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      job_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job       <= b;
    job_valid <= 1'b1;
    track_job(b);
    // Signals read just after the edge still hold their pre-edge values.
    do @(posedge clk); while (job_stall);
  endtask

  function automatic job_beat_t mk_job(bit has, logic [PRIORITY_BITS-1:0] p,
                                       logic [TICK_BITS-1:0] r,
                                       logic [TASK_BITS-1:0] t,
                                       logic [JOB_BITS-1:0] j, bit rdy, bit lst);
    job_beat_t b;
    b.has_job      = has;
    b.priority_req = p;
    b.rel_tick     = r;
    b.task_id      = t;
    b.job_id       = j;
    b.is_ready     = rdy;
    b.last         = lst;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Select channel: stall pattern and checker
  // ---------------------------------------------------------------------------
  // Three moods: never stall, stall now and then, stall nearly always.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        sel_stall <= 1'b0;
      end
      1: begin
        sel_stall <= ($urandom_range(0, 99) < 40);
      end
      default: begin
        sel_stall <= ($urandom_range(0, 99) < 85);
      end
    endcase
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && sel_valid && !sel_stall) begin
      if (expected_sels.size() == 0) begin
        note_failure($sformatf("selection beat with none expected: task %0d job %0d status %0d",
                               sel.sel_task_id, sel.sel_job_id, sel.status));
      end else begin
        want_sel = expected_sels.pop_front();
        if (sel.sel_task_id !== want_sel.sel_task_id ||
            sel.sel_job_id !== want_sel.sel_job_id ||
            sel.status !== want_sel.status) begin
          note_failure($sformatf("task exp %0d got %0d, job exp %0d got %0d, status exp %0d got %0d",
                                 want_sel.sel_task_id, sel.sel_task_id,
                                 want_sel.sel_job_id, sel.sel_job_id,
                                 want_sel.status, sel.status));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Lone last beat without a job; the unused fields carry junk.
  task automatic test_empty_list();
    send_beat(mk_job(1'b0, '1, '1, '1, '1, 1'b1, 1'b1));
  endtask

  // One-job lists at the field extremes.
  task automatic test_field_extremes();
    send_beat(mk_job(1'b1, '1, '1, '1, '1, 1'b1, 1'b1));
    send_beat(mk_job(1'b1, '0, '0, '0, '0, 1'b1, 1'b1));
    send_beat(mk_job(1'b1, 8'h5a, 32'h8000_0001, 8'ha5, 16'h8001, 1'b1, 1'b1));
  endtask

  // Each level of the key decides once; a worse first job must be replaced.
  task automatic test_tie_breaks();
    // priority wins even with a later release
    send_beat(mk_job(1'b1, 8'd9, 32'd1, 8'd1, 16'd1, 1'b1, 1'b0));
    send_beat(mk_job(1'b1, 8'd8, 32'hffff_fff0, 8'd2, 16'd2, 1'b1, 1'b1));
    // equal priority, earlier release wins
    send_beat(mk_job(1'b1, 8'd7, 32'd500, 8'd1, 16'd1, 1'b1, 1'b0));
    send_beat(mk_job(1'b1, 8'd7, 32'd499, 8'd200, 16'd9, 1'b1, 1'b1));
    // equal priority and release, smaller task wins
    send_beat(mk_job(1'b1, 8'd3, 32'd42, 8'd11, 16'd0, 1'b1, 1'b0));
    send_beat(mk_job(1'b1, 8'd3, 32'd42, 8'd10, 16'hffff, 1'b1, 1'b1));
    // only the job id differs
    send_beat(mk_job(1'b1, 8'd3, 32'd42, 8'd10, 16'd6, 1'b1, 1'b0));
    send_beat(mk_job(1'b1, 8'd3, 32'd42, 8'd10, 16'd5, 1'b1, 1'b1));
    // identical key: first one stays
    send_beat(mk_job(1'b1, 8'd1, 32'd2, 8'd3, 16'd4, 1'b1, 1'b0));
    send_beat(mk_job(1'b1, 8'd1, 32'd2, 8'd3, 16'd4, 1'b1, 1'b1));
  endtask

  // Non-ready job anywhere taints the list, even a better ready one follows.
  task automatic test_not_ready();
    send_beat(mk_job(1'b1, 8'd20, 32'd5, 8'd4, 16'd4, 1'b1, 1'b0));
    send_beat(mk_job(1'b1, 8'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b0));
    send_beat(mk_job(1'b1, 8'd1, 32'd1, 8'd1, 16'd1, 1'b1, 1'b1));
    send_beat(mk_job(1'b1, 8'd2, 32'd2, 8'd2, 16'd2, 1'b0, 1'b1));
  endtask

  // Beats without a job add nothing, also when they close the list.
  task automatic test_jobless_beats();
    send_beat(mk_job(1'b1, 8'd50, 32'd50, 8'd50, 16'd50, 1'b1, 1'b0));
    send_beat(mk_job(1'b0, '0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(mk_job(1'b0, '0, '0, '0, '0, 1'b1, 1'b1));
    send_beat(mk_job(1'b1, 8'd6, 32'd6, 8'd6, 16'd6, 1'b0, 1'b0));
    send_beat(mk_job(1'b0, '1, '1, '1, '1, 1'b1, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Random lists. Half of them draw keys from a narrow window so that ties at
  // every key level are common; the rest use full-range fields.
  // ---------------------------------------------------------------------------
  task automatic test_random_lists();
    int jobs_sent;
    int n;
    int k;
    bit narrow;
    logic [PRIORITY_BITS-1:0] p_base;
    logic [TICK_BITS-1:0]     r_base;
    logic [TASK_BITS-1:0]     t_base;
    logic [JOB_BITS-1:0]      j_base;
    job_beat_t b;
    jobs_sent = 0;
    while (jobs_sent < RANDOM_JOBS) begin
      n      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      narrow = 1'($urandom_range(0, 1));
      p_base = PRIORITY_BITS'($urandom);
      r_base = TICK_BITS'($urandom);
      t_base = TASK_BITS'($urandom);
      j_base = JOB_BITS'($urandom);
      for (k = 0; k < n; k++) begin
        b.has_job  = ($urandom_range(0, 19) != 0);
        b.is_ready = ($urandom_range(0, 11) != 0);
        b.last     = (k == n - 1);
        if (narrow) begin
          b.priority_req = PRIORITY_BITS'(p_base + $urandom_range(0, 2));
          b.rel_tick     = TICK_BITS'(r_base + $urandom_range(0, 2));
          b.task_id      = TASK_BITS'(t_base + $urandom_range(0, 2));
          b.job_id       = JOB_BITS'(j_base + $urandom_range(0, 2));
        end else begin
          b.priority_req = PRIORITY_BITS'($urandom);
          b.rel_tick     = TICK_BITS'($urandom);
          b.task_id      = TASK_BITS'($urandom);
          b.job_id       = JOB_BITS'($urandom);
        end
        send_beat(b);
        if (b.has_job) jobs_sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_field_extremes();
    test_tie_breaks();
    test_not_ready();
    test_jobless_beats();
    test_random_lists();
    job_valid <= 1'b0;
    // drain; a hang here is caught by the watchdog
    while (expected_sels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
